// ===== rtl/node_health_tracker_macros.svh =====
// Assertion macros used by the node health tracker checker.
`ifndef NODE_HEALTH_TRACKER_MACROS_SVH
`define NODE_HEALTH_TRACKER_MACROS_SVH

// Same-cycle implication, off while reset is high
`define NHT_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("nht: same-cycle check failed");

// Next-cycle implication, off while reset is high
`define NHT_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("nht: next-cycle check failed");

// Next-cycle implication that also covers the reset cycles
`define NHT_ASSERT_NEXT_RAW(label, ck, ante, cons) \
  label: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("nht: reset sequence check failed");

`endif

// ===== rtl/nht_pkg.sv =====
// Types, codes and helpers shared by the node health tracker modules.
package nht_pkg;

  localparam int NODE_COUNT_DEF = 64;
  localparam int NODE_IDX_W     = 6;
  localparam int TIME_W         = 32;
  localparam int COUNT_W        = 8;
  localparam int PENDING_W      = 7;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 48;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;

  localparam logic [COUNT_W-1:0]   COUNT_MAX   = 8'hFF;
  localparam logic [PENDING_W-1:0] PENDING_MAX = 7'd127;

  // Item kinds
  localparam logic [1:0] MODE_QUERY   = 2'd0;
  localparam logic [1:0] MODE_SUCCESS = 2'd1;
  localparam logic [1:0] MODE_FAILURE = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_FAILURE_LIMIT = 2'd0;
  localparam logic [1:0] REG_SUCCESS_LIMIT = 2'd1;
  localparam logic [1:0] REG_COOLDOWN      = 2'd2;

  localparam logic [COUNT_W-1:0] FAILURE_LIMIT_RST = 8'd3;
  localparam logic [COUNT_W-1:0] SUCCESS_LIMIT_RST = 8'd2;
  localparam logic [TIME_W-1:0]  COOLDOWN_RST      = 32'd30;

  typedef enum logic [1:0] {
    HEALTH_ALIVE   = 2'd0,
    HEALTH_SUSPECT = 2'd1,
    HEALTH_DEAD    = 2'd2
  } health_t;

  // One node entry as stored in the table memory
  typedef struct packed {
    health_t             health;
    logic [COUNT_W-1:0]  fail_cnt;
    logic [COUNT_W-1:0]  succ_cnt;
    logic [TIME_W-1:0]   fail_time;
    logic [TIME_W-1:0]   change_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [COUNT_W-1:0] failure_limit;
    logic [COUNT_W-1:0] success_limit;
    logic [TIME_W-1:0]  cooldown_ticks;
  } cfg_t;

  typedef struct packed {
    entry_t entry;
    logic   went_dead;
    logic   enter_down;
    logic   leave_down;
  } upd_t;

  // Saturating increment of an event counter
  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
  endfunction

endpackage

// ===== rtl/node_health_tracker.sv =====
// Node health tracker: per-node circuit breaker over a table memory.
// An accepted beat is held in the update stage, and its result is registered onto m_tdata.
// Throughput: one item per cycle outside the clearing pass while the output is not stalled;
// each item is one read and one write-back of its node entry, with the last write forwarded
// to the next read. Reset: a clearing pass writes every entry alive, one address at a time,
// with s_tready low; registers return to their defaults and the not-alive count to 0.
module node_health_tracker #(
  parameter int NODE_COUNT = nht_pkg::NODE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // mode[1:0], node_index[7:2], now_time[39:8]
  input  logic [nht_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // node_health[1:0], changed_at[33:2], went_dead[34], pending_count[41:35], zero[47:42]
  output logic [nht_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nht_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [nht_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [nht_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CNT_W = $clog2(NODE_COUNT + 1);
  localparam int EXT_W = IDX_W + nht_pkg::NODE_IDX_W;
  localparam int SAT_W = CNT_W + nht_pkg::PENDING_W;

  nht_pkg::cfg_t   cfg;
  nht_pkg::entry_t rd_entry;
  nht_pkg::entry_t cur_entry;
  nht_pkg::upd_t   upd;

  logic [1:0]                       in_mode;
  logic [nht_pkg::NODE_IDX_W-1:0]   in_node;
  logic [nht_pkg::TIME_W-1:0]       in_now;
  logic [EXT_W-1:0]                 in_ext;
  logic [IDX_W-1:0]                 in_addr;
  logic                             in_hit;
  logic                             s_accept;

  logic                             s1_valid;
  logic [1:0]                       s1_mode;
  logic [IDX_W-1:0]                 s1_addr;
  logic                             s1_hit;
  logic [nht_pkg::TIME_W-1:0]       s1_now;
  logic                             s1_adv;

  logic                             clr_active;
  logic [IDX_W-1:0]                 clr_addr;

  logic                             fwd_valid;
  logic [IDX_W-1:0]                 fwd_addr;
  nht_pkg::entry_t                  fwd_entry;

  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  logic [nht_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [nht_pkg::ENTRY_W-1:0]      ram_rdata;

  logic [CNT_W-1:0]                 down_cnt;
  logic [CNT_W-1:0]                 down_cnt_next;
  logic [SAT_W-1:0]                 down_ext;
  logic [nht_pkg::PENDING_W-1:0]    pending;

  logic [1:0]                       out_health;
  logic [nht_pkg::TIME_W-1:0]       out_changed;
  logic                             out_went_dead;
  logic [nht_pkg::PENDING_W-1:0]    out_pending;

  // Unpack the input beat and range-check the node index
  assign in_mode  = s_tdata[1:0];
  assign in_node  = s_tdata[7:2];
  assign in_now   = s_tdata[39:8];
  assign in_ext   = {{IDX_W{1'b0}}, in_node};
  assign in_addr  = in_ext[IDX_W-1:0];
  assign in_hit   = in_ext < EXT_W'(NODE_COUNT);
  assign s_accept = s_tvalid & s_tready;

  // Advance the update stage when the output register is free
  assign s1_adv   = s1_valid & (~m_tvalid | m_tready);
  assign s_tready = ~clr_active & (~s1_valid | s1_adv);

  nht_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Table write port: clearing pass first, then write-back
  assign ram_we    = clr_active | (s1_adv & s1_hit);
  assign ram_waddr = clr_active ? clr_addr : s1_addr;
  assign ram_wdata = clr_active ? '0 : upd.entry;

  nht_ram #(
    .WIDTH  (nht_pkg::ENTRY_W),
    .DEPTH  (NODE_COUNT),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Forward the entry written on the read edge
  assign rd_entry  = ram_rdata;
  assign cur_entry = (fwd_valid && fwd_addr == s1_addr) ? fwd_entry : rd_entry;

  nht_update u_update (
    .cur      (cur_entry),
    .mode     (s1_mode),
    .now_time (s1_now),
    .cfg      (cfg),
    .upd      (upd)
  );

  // Not-alive count after this item, saturated for the output
  always_comb begin
    down_cnt_next = down_cnt;
    if (s1_hit && upd.enter_down) begin
      down_cnt_next = down_cnt + 1'b1;
    end else if (s1_hit && upd.leave_down && down_cnt != '0) begin
      down_cnt_next = down_cnt - 1'b1;
    end
  end

  assign down_ext = {{nht_pkg::PENDING_W{1'b0}}, down_cnt_next};
  assign pending  = (down_ext > SAT_W'(nht_pkg::PENDING_MAX)) ?
                    nht_pkg::PENDING_MAX : down_ext[nht_pkg::PENDING_W-1:0];

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == IDX_W'(NODE_COUNT - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Update stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
      down_cnt  <= '0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_hit) begin
        fwd_valid <= 1'b1;
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
        down_cnt <= down_cnt_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold item fields in the update stage
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_mode <= in_mode;
      s1_addr <= in_addr;
      s1_hit  <= in_hit;
      s1_now  <= in_now;
    end
  end

  // Capture the written entry for forwarding
  always_ff @(posedge clk) begin
    if (s1_adv && s1_hit) begin
      fwd_addr  <= s1_addr;
      fwd_entry <= upd.entry;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_health    <= s1_hit ? upd.entry.health : nht_pkg::HEALTH_ALIVE;
      out_changed   <= s1_hit ? upd.entry.change_time : '0;
      out_went_dead <= s1_hit & upd.went_dead;
      out_pending   <= pending;
    end
  end

  assign m_tdata = {6'd0, out_pending, out_went_dead, out_changed, out_health};

endmodule

// ===== rtl/nht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/nht_cfg.sv =====
// Configuration register bank behind the APB-style port.
module nht_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nht_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [nht_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [nht_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output nht_pkg::cfg_t                    cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Write registers on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.failure_limit  <= nht_pkg::FAILURE_LIMIT_RST;
      cfg.success_limit  <= nht_pkg::SUCCESS_LIMIT_RST;
      cfg.cooldown_ticks <= nht_pkg::COOLDOWN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        nht_pkg::REG_FAILURE_LIMIT: cfg.failure_limit  <= pwdata[7:0];
        nht_pkg::REG_SUCCESS_LIMIT: cfg.success_limit  <= pwdata[7:0];
        nht_pkg::REG_COOLDOWN:      cfg.cooldown_ticks <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      nht_pkg::REG_FAILURE_LIMIT: prdata = {24'd0, cfg.failure_limit};
      nht_pkg::REG_SUCCESS_LIMIT: prdata = {24'd0, cfg.success_limit};
      nht_pkg::REG_COOLDOWN:      prdata = cfg.cooldown_ticks;
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/nht_update.sv =====
// Next-entry logic: applies one query or report to a node entry.
module nht_update (
  input  nht_pkg::entry_t                 cur,
  input  logic [1:0]                      mode,
  input  logic [nht_pkg::TIME_W-1:0]      now_time,
  input  nht_pkg::cfg_t                   cfg,
  output nht_pkg::upd_t                   upd
);

  nht_pkg::entry_t                  nxt;
  logic [nht_pkg::COUNT_W-1:0]      succ_inc;
  logic [nht_pkg::COUNT_W-1:0]      fail_inc;
  logic [nht_pkg::TIME_W-1:0]       elapsed;
  logic                             cooling;
  logic                             went_dead;

  assign succ_inc = nht_pkg::count_up(cur.succ_cnt);
  assign fail_inc = nht_pkg::count_up(cur.fail_cnt);
  assign elapsed  = now_time - cur.fail_time;
  assign cooling  = (cur.health == nht_pkg::HEALTH_DEAD) && (elapsed < cfg.cooldown_ticks);

  // Apply the report
  always_comb begin
    nxt       = cur;
    went_dead = 1'b0;
    case (mode)
      nht_pkg::MODE_SUCCESS: begin
        nxt.fail_cnt = '0;
        if (cur.health != nht_pkg::HEALTH_ALIVE) begin
          if (!cooling && succ_inc >= cfg.success_limit) begin
            nxt.health      = nht_pkg::HEALTH_ALIVE;
            nxt.succ_cnt    = '0;
            nxt.change_time = now_time;
          end else begin
            nxt.succ_cnt = succ_inc;
          end
        end else begin
          nxt.change_time = now_time;
          nxt.succ_cnt    = (succ_inc > cfg.success_limit) ? cfg.success_limit : succ_inc;
        end
      end
      nht_pkg::MODE_FAILURE: begin
        nxt.succ_cnt    = '0;
        nxt.change_time = now_time;
        if (cur.health == nht_pkg::HEALTH_DEAD) begin
          nxt.fail_time = now_time;
        end else if (fail_inc >= cfg.failure_limit) begin
          nxt.health    = nht_pkg::HEALTH_DEAD;
          nxt.fail_cnt  = '0;
          nxt.fail_time = now_time;
          went_dead     = 1'b1;
        end else begin
          nxt.health   = nht_pkg::HEALTH_SUSPECT;
          nxt.fail_cnt = fail_inc;
        end
      end
      default: ;
    endcase
  end

  // Track transitions into and out of the not-alive set
  always_comb begin
    upd.entry      = nxt;
    upd.went_dead  = went_dead;
    upd.enter_down = (cur.health == nht_pkg::HEALTH_ALIVE) &&
                     (nxt.health != nht_pkg::HEALTH_ALIVE);
    upd.leave_down = (cur.health != nht_pkg::HEALTH_ALIVE) &&
                     (nxt.health == nht_pkg::HEALTH_ALIVE);
  end

endmodule

// ===== rtl/nht_checker.sv =====
// Port-level checker for the node health tracker, bound to the top level.
`include "node_health_tracker_macros.svh"

module nht_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [nht_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  // A stalled result beat stays put
  `NHT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A node that just went dead reports dead
  `NHT_ASSERT_IMPL(a_went_dead_state, clk, rst, m_tvalid && m_tdata[34], m_tdata[1:0] == nht_pkg::HEALTH_DEAD)

  // Reset starts the clearing pass, so no input beat is taken right after it
  `NHT_ASSERT_NEXT_RAW(a_clear_after_rst, clk, rst, !s_tready)

endmodule

bind node_health_tracker nht_checker u_nht_checker (.*);
